FILE: rtl/length_prefixed_packet_deframer_unit_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpd_pkg.sv
// Shared types and constants of the length-prefixed packet deframer.
package lpd_pkg;

  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned LEN_W       = 15;
  localparam logic [LEN_W-1:0] MAX_RESET = 15'd4096;

  // Result queue between the parser and the output unpacker.
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queue entry: a bundle of one to four result transfers.
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]                last_idx;  // index of the final transfer of the bundle
    logic                      last;      // final transfer closes a packet
    logic                      error;     // bundle is the single error result
  } entry_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

FILE: rtl/lpd_parser.sv
// Header/body parser: input register, length check and result bundle generation.
module lpd_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0]       cfg_wr_data,
  input  logic                            accept,
  input  logic [7:0]                      data_byte,
  output logic                            push,
  output lpd_pkg::entry_t                 entry
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_ERROR  = 2'd2
  } phase_t;

  localparam logic [lpd_pkg::LEN_W-1:0] HDR_LEN = lpd_pkg::LEN_W'(lpd_pkg::HDR_BYTES);

  phase_t                      phase_r, phase_nxt;
  logic [1:0]                  hcnt_r, hcnt_nxt;
  logic [2:0][7:0]             hdr_r;
  logic [lpd_pkg::LEN_W-1:0]   remain_r, remain_nxt;
  logic [lpd_pkg::LEN_W-1:0]   max_r;
  logic                        in_valid_r;
  logic [7:0]                  in_byte_r;

  logic [15:0]                 raw_len;
  logic [lpd_pkg::LEN_W-1:0]   len;
  logic [lpd_pkg::LEN_W-1:0]   remain_dec;
  logic                        len_ok;

  assign raw_len    = {hdr_r[1], hdr_r[0]};
  assign len        = raw_len[lpd_pkg::LEN_W-1:0];
  assign len_ok     = !raw_len[15] && (len >= HDR_LEN) && (len <= max_r);
  assign remain_dec = remain_r - lpd_pkg::LEN_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    remain_nxt = remain_r;
    push       = 1'b0;
    entry      = '0;
    if (in_valid_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hcnt_r != 2'd3) begin
            hcnt_nxt = hcnt_r + 2'd1;
          end else begin
            hcnt_nxt = 2'd0;
            push     = 1'b1;
            if (!len_ok) begin
              phase_nxt   = PH_ERROR;
              entry.error = 1'b1;
            end else begin
              entry.bytes    = {in_byte_r, hdr_r[2], hdr_r[1], hdr_r[0]};
              entry.last_idx = 2'd3;
              if (len == HDR_LEN) begin
                entry.last = 1'b1;
              end else begin
                remain_nxt = len - HDR_LEN;
                phase_nxt  = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          push           = 1'b1;
          remain_nxt     = remain_dec;
          entry.bytes[0] = in_byte_r;
          if (remain_dec == '0) begin
            entry.last = 1'b1;
            phase_nxt  = PH_HEADER;
            hcnt_nxt   = 2'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hcnt_r     <= 2'd0;
      remain_r   <= '0;
      max_r      <= lpd_pkg::MAX_RESET;
      in_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hcnt_r     <= hcnt_nxt;
      remain_r   <= remain_nxt;
      in_valid_r <= accept;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= data_byte;
    end
    if (in_valid_r && phase_r == PH_HEADER && hcnt_r != 2'd3) begin
      hdr_r[hcnt_r] <= in_byte_r;
    end
  end

endmodule

FILE: rtl/lpd_queue.sv
// Small result-bundle queue with one push and one pop per cycle.
module lpd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lpd_pkg::entry_t        push_entry,
  input  logic                   pop,
  output lpd_pkg::entry_t        head,
  output lpd_pkg::queue_status_t status
);

  lpd_pkg::entry_t                   mem_r [lpd_pkg::QUEUE_DEPTH];
  logic [lpd_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [lpd_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [lpd_pkg::QCNT_W-1:0]        count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + lpd_pkg::QCNT_W'(1);
      2'b01:   count_nxt = count_r - lpd_pkg::QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + lpd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + lpd_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/lpd_unpacker.sv
// Output register that splits each result bundle into single-byte transfers.
module lpd_unpacker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  lpd_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_error
);

  lpd_pkg::entry_t cur_r;
  logic [1:0]      idx_r;
  logic            valid_r;
  logic            xfer;
  logic            done;

  assign xfer  = valid_r && !out_stall;
  assign done  = xfer && (idx_r == cur_r.last_idx);
  assign q_pop = !q_empty && (!valid_r || done);

  assign out_valid = valid_r;
  assign out_byte  = cur_r.bytes[idx_r];
  assign out_last  = cur_r.last && (idx_r == cur_r.last_idx);
  assign out_error = cur_r.error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (xfer) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

endmodule

FILE: rtl/length_prefixed_packet_deframer_unit.sv
// Top level of the length-prefixed packet deframer.
// The deframer takes one raw byte per input transfer and, while neither side
// stalls, sustains one byte per cycle in both directions. Each packet opens
// with a 4-byte header whose first two bytes are the total packet length
// (header included) as a little-endian signed 16-bit number. The first three
// header bytes are held; on the fourth, the length must satisfy
// 4 <= length <= max_packet_bytes. A good header comes out as four transfers
// (the header bytes in order), followed by one transfer per body byte, with
// out_last set on the final byte of the packet. A bad header gives a single
// transfer with out_error set and out_byte zero, after which every input byte
// is dropped until reset. An accepted byte passes through the input register
// and parser, then the bundle queue, then the output register. The four header
// transfers go out while the next packet's first three header bytes produce
// nothing, so the rate holds; the body bytes that arrive during a header burst
// wait in the queue, which then holds at most four bundles, so in_stall rises
// only when the downstream side stalls long enough to leave fewer than two free
// entries in the eight-entry result queue.
// max_packet_bytes (reset 4096) is written through cfg_wr_en/cfg_wr_data and
// should only change while the block is idle.
module length_prefixed_packet_deframer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_last,
  output logic                      out_error
);

  `include "length_prefixed_packet_deframer_unit_assert.svh"

  logic                   in_accept;
  logic                   q_push;
  logic                   q_pop;
  lpd_pkg::entry_t        q_entry;
  lpd_pkg::entry_t        q_head;
  lpd_pkg::queue_status_t q_status;

  // A byte accepted now may push one bundle next cycle, and the byte already in
  // the parser may push one this cycle, so two free entries are kept in reserve.
  assign in_stall  = (q_status.count > lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH - 2));
  assign in_accept = in_valid && !in_stall;

  lpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_accept),
    .data_byte   (in_data_byte),
    .push        (q_push),
    .entry       (q_entry)
  );

  lpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  lpd_unpacker u_unpacker (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_status.empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

  // The stall reserve must keep the queue from ever being pushed while full without a pop.
  `LPD_ASSERT_NOW(a_queue_no_overflow, q_push && !q_pop, q_status.count < lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH), "result queue pushed while full")

  // A pop never happens on an empty queue.
  `LPD_ASSERT_NOW(a_queue_no_underflow, q_pop, !q_status.empty, "result queue popped while empty")

  // The error result never closes a packet.
  `LPD_ASSERT_NOW(a_error_not_last, out_valid && out_error, !out_last, "error transfer marked as last")

  // Once the error result has been transferred, nothing else may follow.
  `LPD_ASSERT_NEXT(a_silent_after_error, out_valid && out_error && !out_stall, !out_valid && q_status.empty, "output after error result")

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the length-prefixed packet deframer.
module tb;

  localparam int unsigned HDR_LEN        = lpd_pkg::HDR_BYTES;
  localparam int unsigned LEN_W          = lpd_pkg::LEN_W;
  localparam int unsigned IDLE_PCT       = 36;
  localparam int unsigned RX_HOLD_CYCLES = 80;
  // Time for the pipeline to settle, taken with a wide margin.
  localparam int unsigned SETTLE_CYCLES  = 12;

  // Where the predicted deframer stands in the byte stream.
  typedef enum logic [1:0] {
    SEEK_HEADER,
    IN_BODY,
    LOCKED_OUT
  } deframe_state_t;

  // Ways in which the closing header of the run is made invalid.
  typedef enum int unsigned {
    NEG_LENGTH,
    SHORT_LENGTH,
    LONG_LENGTH,
    LIMIT_BELOW_HDR
  } bad_header_t;

  // One output transfer as the deframer should present it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             out_error;

  // Stream bytes waiting to be offered, and transfers the deframer still owes us.
  logic [7:0] pending_bytes[$];
  beat_t      expected_beats[$];

  // Predicted deframer state. The limit starts at the reset value of the register.
  deframe_state_t   deframe_state = SEEK_HEADER;
  logic [7:0]       hdr_held[3];
  logic [1:0]       hdr_count = 2'd0;
  logic [LEN_W-1:0] body_left = '0;
  logic [LEN_W-1:0] limit_bytes = lpd_pkg::MAX_RESET;

  int unsigned tx_idle_pct = IDLE_PCT;
  int unsigned rx_idle_pct = IDLE_PCT;
  logic        rx_hold = 1'b0;
  event        rx_hold_start;
  int unsigned mismatch_count = 0;

  always #5 clk = ~clk;

  length_prefixed_packet_deframer_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_error    (out_error)
  );

  // Advances the predicted deframer by one accepted byte and queues whatever
  // transfers that byte releases. The first three header bytes release nothing;
  // the fourth either releases the whole header or the single error transfer.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0]      raw;
    logic [LEN_W-1:0] len;
    logic             good;
    case (deframe_state)
      SEEK_HEADER: begin
        if (hdr_count < 2'd3) begin
          hdr_held[hdr_count] = b;
          hdr_count = hdr_count + 2'd1;
        end else begin
          // The length is a signed little-endian halfword, so bit 15 means negative.
          raw = {hdr_held[1], hdr_held[0]};
          len = raw[LEN_W-1:0];
          good = !raw[15] && len >= LEN_W'(HDR_LEN) && len <= limit_bytes;
          hdr_count = 2'd0;
          if (!good) begin
            // Once locked out, the deframer swallows everything until reset.
            deframe_state = LOCKED_OUT;
            expected_beats.push_back('{data: 8'h00, last: 1'b0, err: 1'b1});
          end else begin
            for (int k = 0; k < 3; k++) begin
              expected_beats.push_back('{data: hdr_held[k], last: 1'b0, err: 1'b0});
            end
            if (len == LEN_W'(HDR_LEN)) begin
              // A header-only packet closes on its own fourth byte.
              expected_beats.push_back('{data: b, last: 1'b1, err: 1'b0});
            end else begin
              expected_beats.push_back('{data: b, last: 1'b0, err: 1'b0});
              body_left = len - LEN_W'(HDR_LEN);
              deframe_state = IN_BODY;
            end
          end
        end
      end
      IN_BODY: begin
        body_left = body_left - LEN_W'(1);
        expected_beats.push_back('{data: b, last: (body_left == '0), err: 1'b0});
        if (body_left == '0) begin
          deframe_state = SEEK_HEADER;
        end
      end
      default: begin
        // Locked out: the byte is dropped and nothing comes out.
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH at %0t: %s, got 0x%02h, expected 0x%02h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Input driver. A transfer happens at an edge with in_valid high and in_stall
  // low; the accepted byte is fed to the predictor right there. The payload is
  // only replaced when the current one has gone or nothing was on offer, so a
  // stalled byte stays put. in_valid gets at most one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte);
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid     <= 1'b1;
          in_data_byte <= pending_bytes.pop_front();
        end else begin
          in_valid     <= 1'b0;
          in_data_byte <= 8'($urandom);
        end
      end
    end
  end

  // Output monitor. Every transfer is matched against the oldest expected one,
  // field by field. out_stall is drawn fresh each cycle unless a long hold-off
  // is in progress.
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("transfer with nothing expected", out_byte, 8'h00);
      end else begin
        want = expected_beats.pop_front();
        if (out_byte !== want.data) begin
          report_mismatch("out_byte", out_byte, want.data);
        end
        if (out_last !== want.last) begin
          report_mismatch("out_last", 8'(out_last), 8'(want.last));
        end
        if (out_error !== want.err) begin
          report_mismatch("out_error", 8'(out_error), 8'(want.err));
        end
      end
    end
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // Long receiver hold-off, counted here in clock cycles. While it lasts the
  // result queue inside the deframer fills up and in_stall has to rise.
  always begin
    @(rx_hold_start);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic queue_header(input logic [15:0] raw, input logic [7:0] b2,
                              input logic [7:0] b3);
    pending_bytes.push_back(raw[7:0]);
    pending_bytes.push_back(raw[15:8]);
    pending_bytes.push_back(b2);
    pending_bytes.push_back(b3);
  endtask

  task automatic queue_packet(input logic [LEN_W-1:0] len, input logic [7:0] b2,
                              input logic [7:0] b3);
    queue_header({1'b0, len}, b2, b3);
    for (int unsigned i = HDR_LEN; i < len; i++) begin
      pending_bytes.push_back(8'($urandom));
    end
  endtask

  // Well-formed packets under the current limit. Most are short; when the limit
  // is small, some packets land exactly on it.
  task automatic queue_random_packets(input int unsigned n_bytes);
    int unsigned added;
    int unsigned len;
    added = 0;
    while (added < n_bytes) begin
      if (limit_bytes <= 64 && $urandom_range(5) == 0) begin
        len = limit_bytes;
      end else begin
        len = $urandom_range(HDR_LEN, (limit_bytes < 30) ? int'(limit_bytes) : 30);
      end
      queue_packet(LEN_W'(len), 8'($urandom), 8'($urandom));
      added += len;
    end
  endtask

  // Returns once every queued byte has been taken and every expected transfer
  // has come out. Checked on the falling edge, where everything has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0);
  endtask

  // The limit may only change while the deframer is idle, so the task waits for
  // the pipeline to drain and then settle before the write.
  task automatic write_limit(input logic [LEN_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    limit_bytes = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : sequencer
    bad_header_t bad_kind;
    logic [15:0] bad_raw;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first at the reset limit that was never written. The
    // header-only packet must close with last on its fourth byte, and the
    // filler header bytes sweep all-zero and all-one values.
    queue_packet(LEN_W'(4), 8'h00, 8'hFF);
    queue_packet(LEN_W'(5), 8'hFF, 8'h00);
    queue_packet(LEN_W'(6), 8'hA5, 8'h5A);
    // Smallest legal limit: only a header-only packet fits.
    write_limit(LEN_W'(4));
    queue_header(16'h0004, 8'hFF, 8'hFF);
    // One above it, with a packet exactly at the limit.
    write_limit(LEN_W'(5));
    queue_packet(LEN_W'(5), 8'h80, 8'h7F);

    // Largest limit, with short packets well inside it.
    write_limit({LEN_W{1'b1}});
    queue_random_packets(20);
    queue_random_packets(10);

    // A stretch with no idling on either side, at a small limit.
    write_limit(LEN_W'($urandom_range(4, 16)));
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_packets(60);
    wait_drained();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;

    // Back pressure: the sender offers on every cycle while the receiver holds
    // off, so the deframer fills and stalls its input.
    write_limit(LEN_W'($urandom_range(17, 64)));
    queue_random_packets(50);
    tx_idle_pct = 0;
    -> rx_hold_start;
    wait_drained();
    tx_idle_pct = IDLE_PCT;

    // Large limit, with the sender pausing midway until the deframer has
    // delivered everything it owes.
    write_limit(LEN_W'($urandom_range(65, 32767)));
    queue_random_packets(25);
    wait_drained();
    queue_random_packets(25);

    write_limit(LEN_W'($urandom_range(4, 64)));
    queue_random_packets(60);

    // The run ends with a rejected header, since nothing but reset leaves the
    // locked-out state. The seed picks how the header is made invalid.
    bad_kind = bad_header_t'($urandom_range(0, 3));
    if (bad_kind == LIMIT_BELOW_HDR) begin
      // With the limit under the header size every header is refused.
      write_limit(LEN_W'($urandom_range(0, 3)));
      bad_raw = 16'($urandom_range(4, 64));
    end else begin
      write_limit(LEN_W'($urandom_range(4, 1000)));
      queue_random_packets(30);
      case (bad_kind)
        NEG_LENGTH: begin
          bad_raw = {1'b1, 15'($urandom)};
        end
        SHORT_LENGTH: begin
          bad_raw = 16'($urandom_range(0, 3));
        end
        default: begin
          if ($urandom_range(1) == 0) begin
            bad_raw = 16'(limit_bytes) + 16'd1;
          end else begin
            bad_raw = 16'($urandom_range(int'(limit_bytes) + 1, 32767));
          end
        end
      endcase
    end
    queue_header(bad_raw, 8'($urandom), 8'($urandom));
    // Bytes after the error transfer must all be swallowed.
    repeat (20) pending_bytes.push_back(8'($urandom));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_parser.sv
rtl/lpd_queue.sv
rtl/lpd_unpacker.sv
rtl/length_prefixed_packet_deframer_unit.sv
dv/tb.sv
